### hdl/rccs_pkg.sv
// ----------------------------------------------------------------------------
// rccs_pkg
// Shared types, constants and the bytewise CRC-32 update for the redundant
// copy checker.
// ----------------------------------------------------------------------------
package rccs_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // input item kinds on tuser
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_LAST   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              copy;
    logic [CRC_W-1:0]  crc;
    logic [GEN_W-1:0]  gen;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/rccs_front.sv
// ----------------------------------------------------------------------------
// rccs_front
// Accepts input transactions, classifies them into header, data and last
// data commands, and queues them for the back end.
// ----------------------------------------------------------------------------
module rccs_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rccs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              cmd_valid,
  input  logic                              cmd_pop,
  output rccs_pkg::cmd_t                    cmd
);
  import rccs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             in_cmd;
  logic             push;

  always_comb begin
    in_cmd.copy = in_tdata[0];
    in_cmd.crc  = in_tdata[32:1];
    in_cmd.gen  = in_tdata[64:33];
    in_cmd.data = in_tdata[72:65];
    unique case (in_tuser)
      REQ_HEADER: in_cmd.kind = CMD_HEADER;
      REQ_DATA:   in_cmd.kind = in_tlast ? CMD_LAST : CMD_DATA;
      default:    in_cmd.kind = CMD_HEADER;
    endcase
  end

  assign in_tready = (count_r != CNT_FULL);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

### hdl/rccs_back.sv
// ----------------------------------------------------------------------------
// rccs_back
// Executes queued commands against the per-copy CRC state and drives the
// registered result channel, including the choice between the two copies.
// ----------------------------------------------------------------------------
module rccs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  rccs_pkg::cmd_t                    cmd,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rccs_pkg::OUT_DATA_W-1:0]   out_tdata  // done_copy, computed_crc,
                                                       // crc_match, decision_ready,
                                                       // chosen_copy, none_valid, pad
);
  import rccs_pkg::*;

  logic [CRC_W-1:0] running_crc_r [2];
  logic [CRC_W-1:0] expected_crc_r [2];
  logic [GEN_W-1:0] copy_gen_r [2];
  logic [1:0]       checked_r, checked_nxt;
  logic [1:0]       valid_r, valid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [CRC_W-1:0] crc_upd;
  logic [CRC_W-1:0] computed;
  logic             match;
  logic             ready;
  logic             chosen;
  logic             none;
  logic             is_last;

  assign is_last = (cmd.kind == CMD_LAST);
  // a result needs the output slot, other commands never wait
  assign cmd_pop = cmd_valid && (!is_last || !out_valid_r || out_tready);

  assign crc_upd  = crc_byte(running_crc_r[cmd.copy], cmd.data);
  assign computed = ~crc_upd;
  assign match    = (computed == expected_crc_r[cmd.copy]);

  always_comb begin
    checked_nxt = checked_r;
    valid_nxt   = valid_r;
    if (cmd_pop) begin
      unique case (cmd.kind)
        CMD_HEADER: begin
          checked_nxt[cmd.copy] = 1'b0;
          valid_nxt[cmd.copy]   = 1'b0;
        end
        CMD_LAST: begin
          checked_nxt[cmd.copy] = 1'b1;
          valid_nxt[cmd.copy]   = match;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ready  = checked_nxt[0] && checked_nxt[1];
    chosen = 1'b0;
    none   = 1'b0;
    if (ready) begin
      unique case (valid_nxt)
        2'b01:   chosen = 1'b0;
        2'b10:   chosen = 1'b1;
        2'b00:   none = 1'b1;
        default: chosen = (copy_gen_r[1] > copy_gen_r[0]);
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_pop && is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        running_crc_r[i]  <= CRC_ALL_ONES;
        expected_crc_r[i] <= '0;
        copy_gen_r[i]     <= '0;
      end
      checked_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      checked_r   <= checked_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd_pop) begin
        unique case (cmd.kind)
          CMD_HEADER: begin
            running_crc_r[cmd.copy]  <= CRC_ALL_ONES;
            expected_crc_r[cmd.copy] <= cmd.crc;
            copy_gen_r[cmd.copy]     <= cmd.gen;
          end
          CMD_DATA: running_crc_r[cmd.copy] <= crc_upd;
          CMD_LAST: running_crc_r[cmd.copy] <= CRC_ALL_ONES;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_last) begin
      out_data_r <= {3'b000, none, chosen, ready, match, computed, cmd.copy};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/redundant_copy_crc_selector.sv
// ----------------------------------------------------------------------------
// redundant_copy_crc_selector
// Checks two redundant copies of a stored record by CRC-32 and picks one.
// ----------------------------------------------------------------------------
// Each copy is sent as a header transaction (tuser 0) carrying its stored CRC
// and generation, followed by payload bytes (tuser 1), the final byte marked
// with tlast. The block runs a reflected CRC-32 per copy and, on the last
// byte only, returns one result transaction with the copy index, computed
// CRC, match flag and, once both copies are checked, the chosen copy (one
// valid copy wins; two valid copies go by the higher generation, copy 0 on a
// tie) or a none-valid flag. One input transaction is taken every cycle while
// the front queue of QUEUE_DEPTH entries has room; that queue absorbs output
// stalls, and the bytewise CRC update in the back end forms the feedback
// loop through the running CRC register. A result passes through the queue
// and the registered output slot after its last byte is accepted.
module redundant_copy_crc_selector #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rccs_pkg::IN_DATA_W-1:0]    in_tdata,   // copy_index, stored_crc,
                                                        // generation_flags, data_byte, pad
  input  logic                              in_tuser,   // req_type
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rccs_pkg::OUT_DATA_W-1:0]   out_tdata   // done_copy, computed_crc,
                                                        // crc_match, decision_ready,
                                                        // chosen_copy, none_valid, pad
);
  import rccs_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  rccs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  rccs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
